>>> rtl/irregular_grid_bilinear_interpolator_top_assert.svh
// Assertion macros for the interpolator RTL
`ifndef IRREGULAR_GRID_BILINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define IRREGULAR_GRID_BILINEAR_INTERPOLATOR_TOP_ASSERT_SVH
// same-cycle implication, clocked on i_clk, off during reset
`define IGBI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define IGBI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/igbi_pkg.sv
// Package: shared types and constants of the bilinear interpolator
`timescale 1ns / 1ps
package igbi_pkg;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd48;
    localparam logic [CNT_W-1:0] MUL_STEPS = 6'd30;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;
    localparam logic signed [48:0] LAT_FRAC_LIMIT = 49'sd536870912;

    localparam logic CFG_P_COUNT = 1'b0;
    localparam logic CFG_L_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD_P = 2'd0,
        KIND_LOAD_L = 2'd1,
        KIND_LOAD_T = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_RD_FIRST, OP_RD_LAST, OP_CHECK, OP_ZERO,
        OP_SRCH_RD, OP_SRCH_CMP, OP_RD_LO, OP_DIV_START, OP_DIV_STEP,
        OP_FRAC_STORE, OP_BASE, OP_T_RD, OP_T_CAP, OP_MUL_START,
        OP_MUL_STEP, OP_MUL_STORE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       lat;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic out_rng;
        logic hit_or_last;
        logic unit_done;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/igbi_ctrl.sv
// Controller: query sequencer state machine
`timescale 1ns / 1ps
`include "irregular_grid_bilinear_interpolator_top_assert.svh"
module igbi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_is_query,
    input  igbi_pkg::t_stat i_stat,
    output igbi_pkg::t_cmd  o_cmd,
    output logic            o_ready
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_RD0    = 17'h00002,
        S_RDN    = 17'h00004,
        S_CHK    = 17'h00008,
        S_ZERO   = 17'h00010,
        S_SRD    = 17'h00020,
        S_SCMP   = 17'h00040,
        S_RLO    = 17'h00080,
        S_DSTART = 17'h00100,
        S_DIV    = 17'h00200,
        S_FRAC   = 17'h00400,
        S_BASE   = 17'h00800,
        S_TRD    = 17'h01000,
        S_TCAP   = 17'h02000,
        S_MSTART = 17'h04000,
        S_MUL    = 17'h08000,
        S_MSTORE = 17'h10000
    } t_state;

    t_state     r_state, n_state;
    logic       r_lat, n_lat;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state   = r_state;
        n_lat     = r_lat;
        n_sel     = r_sel;
        o_cmd.op  = igbi_pkg::OP_NOP;
        o_cmd.lat = r_lat;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = igbi_pkg::OP_ACCEPT;
                    if (i_is_query) n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.op = igbi_pkg::OP_RD_FIRST;
                n_state  = S_RDN;
            end
            S_RDN: begin
                o_cmd.op = igbi_pkg::OP_RD_LAST;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = igbi_pkg::OP_CHECK;
                n_lat    = 1'b0;
                n_state  = i_stat.out_rng ? S_ZERO : S_SRD;
            end
            S_ZERO: begin
                o_cmd.op = igbi_pkg::OP_ZERO;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_SRD: begin
                o_cmd.op = igbi_pkg::OP_SRCH_RD;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.op = igbi_pkg::OP_SRCH_CMP;
                n_state  = i_stat.hit_or_last ? S_RLO : S_SRD;
            end
            S_RLO: begin
                o_cmd.op = igbi_pkg::OP_RD_LO;
                n_state  = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.op = igbi_pkg::OP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = igbi_pkg::OP_DIV_STEP;
                if (i_stat.unit_done) n_state = S_FRAC;
            end
            S_FRAC: begin
                o_cmd.op = igbi_pkg::OP_FRAC_STORE;
                if (r_lat) begin
                    n_sel   = 2'd0;
                    n_state = S_BASE;
                end else begin
                    n_lat   = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_BASE: begin
                o_cmd.op = igbi_pkg::OP_BASE;
                n_state  = S_TRD;
            end
            S_TRD: begin
                o_cmd.op = igbi_pkg::OP_T_RD;
                if (r_sel == 2'd3) begin
                    n_sel   = 2'd0;
                    n_state = S_TCAP;
                end else begin
                    n_sel = r_sel + 2'd1;
                end
            end
            S_TCAP: begin
                o_cmd.op = igbi_pkg::OP_T_CAP;
                n_state  = S_MSTART;
            end
            S_MSTART: begin
                o_cmd.op = igbi_pkg::OP_MUL_START;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = igbi_pkg::OP_MUL_STEP;
                if (i_stat.unit_done) n_state = S_MSTORE;
            end
            S_MSTORE: begin
                o_cmd.op = igbi_pkg::OP_MUL_STORE;
                if (r_sel == 2'd2) begin
                    if (i_stat.out_free) n_state = S_IDLE;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_MSTART;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lat   <= 1'b0;
            r_sel   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_lat   <= n_lat;
            r_sel   <= n_sel;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    `IGBI_ASSERT_NXT(a_range_exit, (r_state == S_CHK) && i_stat.out_rng, r_state == S_ZERO, "out of range query went on")
    `IGBI_ASSERT_NXT(a_div_hold, (r_state == S_DIV) && !i_stat.unit_done, r_state == S_DIV, "divide left early")
    `IGBI_ASSERT_NXT(a_load_idle, (r_state == S_IDLE) && i_valid && !i_is_query, r_state == S_IDLE, "load started a query")
    `IGBI_ASSERT_IMP(a_ret_free, (r_state == S_MSTORE) && (r_sel == 2'd2) && (n_state == S_IDLE), i_stat.out_free, "result dropped")

endmodule

>>> rtl/igbi_dp.sv
// Datapath: breakpoint and table memories, search compare, serial divider and multiplier
`timescale 1ns / 1ps
module igbi_dp #(
    parameter int MAX_P = 64,
    parameter int MAX_L = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  igbi_pkg::t_cmd            i_cmd,
    output igbi_pkg::t_stat           o_stat,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [igbi_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [1:0]                i_kind,
    input  logic [11:0]               i_index,
    input  logic signed [31:0]        i_value,
    input  logic signed [23:0]        i_qlat,
    input  logic signed [31:0]        i_qlp,
    input  logic                      i_m_ready,
    output logic                      o_m_valid,
    output logic signed [31:0]        o_m_data,
    output logic                      o_m_range
);

    localparam int TDEPTH = MAX_P * MAX_L;
    localparam int PW  = $clog2(MAX_P);
    localparam int LW  = $clog2(MAX_L);
    localparam int TW  = $clog2(TDEPTH);
    localparam int PCW = $clog2(MAX_P + 1);
    localparam int LCW = $clog2(MAX_L + 1);
    localparam int IW  = (PCW > LCW) ? PCW : LCW;

    logic signed [31:0] r_pmem [MAX_P];
    logic signed [31:0] r_lmem [MAX_L];
    logic signed [31:0] r_tmem [TDEPTH];
    logic signed [31:0] r_pdat, r_ldat, r_tdat;

    logic [igbi_pkg::CFG_W-1:0] r_pcfg, r_lcfg;
    logic signed [23:0] r_qlat;
    logic signed [31:0] r_qlp, r_b0, r_b1;
    logic           r_above;
    logic [IW-1:0]  r_idx;
    logic [PW-1:0]  r_k;
    logic [LW-1:0]  r_j;
    logic [TW-1:0]  r_base;
    logic signed [31:0] r_v00, r_v01, r_v10, r_v11;
    logic signed [30:0] r_fl;
    logic signed [17:0] r_fp;
    logic signed [47:0] r_a, r_b;
    logic [igbi_pkg::CNT_W-1:0] r_cnt;
    logic [47:0] r_dq;
    logic [31:0] r_dvs, r_rem;
    logic        r_dneg, r_dzero;
    logic [77:0] r_mx, r_acc;
    logic [29:0] r_my;
    logic        r_mneg;
    logic        r_ovalid, r_orange;
    logic signed [31:0] r_odata;

    logic [PCW-1:0] w_np;
    logic [LCW-1:0] w_nl;
    logic [31:0]    w_pc, w_lc;
    logic           w_acc, w_pwe, w_lwe, w_twe, w_pre, w_lre, w_tre;
    logic [PW-1:0]  w_pra;
    logic [LW-1:0]  w_lra;
    logic [TW-1:0]  w_tra;
    logic           w_hit, w_last, w_free;
    logic signed [32:0] w_q, w_lo, w_num, w_den;
    logic [31:0]    w_anum, w_aden;
    logic [32:0]    w_trial;
    logic signed [48:0] w_frac;
    logic signed [47:0] w_x;
    logic signed [30:0] w_y;
    logic [47:0]    w_ax;
    logic signed [30:0] w_ay;
    logic signed [78:0] w_prod, w_rnd;
    logic signed [63:0] w_r64, w_sum;
    logic signed [31:0] w_sat;

    // effective counts clamped to [2, depth]
    always_comb begin
        w_pc = 32'(r_pcfg);
        w_lc = 32'(r_lcfg);
        if (w_pc < 32'd2) w_pc = 32'd2;
        if (w_pc > 32'(MAX_P)) w_pc = 32'(MAX_P);
        if (w_lc < 32'd2) w_lc = 32'd2;
        if (w_lc > 32'(MAX_L)) w_lc = 32'(MAX_L);
        w_np = PCW'(w_pc);
        w_nl = LCW'(w_lc);
    end

    assign w_acc = (i_cmd.op == igbi_pkg::OP_ACCEPT);
    assign w_pwe = w_acc && (i_kind == igbi_pkg::KIND_LOAD_P) && (32'(i_index) < 32'(MAX_P));
    assign w_lwe = w_acc && (i_kind == igbi_pkg::KIND_LOAD_L) && (32'(i_index) < 32'(MAX_L));
    assign w_twe = w_acc && (i_kind == igbi_pkg::KIND_LOAD_T) && (32'(i_index) < 32'(TDEPTH));

    always_comb begin
        w_pre = 1'b0;
        w_lre = 1'b0;
        w_tre = 1'b0;
        w_pra = '0;
        w_lra = '0;
        w_tra = r_base + (i_cmd.sel[1] ? TW'(w_nl) : TW'(0)) + TW'(r_j) + TW'(i_cmd.sel[0]);
        case (i_cmd.op)
            igbi_pkg::OP_RD_FIRST: w_pre = 1'b1;
            igbi_pkg::OP_RD_LAST: begin
                w_pre = 1'b1;
                w_lre = 1'b1;
                w_pra = PW'(w_np - PCW'(1));
                w_lra = LW'(w_nl - LCW'(1));
            end
            igbi_pkg::OP_SRCH_RD: begin
                w_pre = !i_cmd.lat;
                w_lre = i_cmd.lat;
                w_pra = r_idx[PW-1:0];
                w_lra = r_idx[LW-1:0];
            end
            igbi_pkg::OP_RD_LO: begin
                w_pre = !i_cmd.lat;
                w_lre = i_cmd.lat;
                w_pra = r_k;
                w_lra = r_j;
            end
            igbi_pkg::OP_T_RD: w_tre = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) r_pmem[i_index[PW-1:0]] <= i_value;
        if (w_pre) r_pdat <= r_pmem[w_pra];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) r_lmem[i_index[LW-1:0]] <= i_value;
        if (w_lre) r_ldat <= r_lmem[w_lra];
    end

    always_ff @(posedge i_clk) begin
        if (w_twe) r_tmem[TW'(i_index)] <= i_value;
        if (w_tre) r_tdat <= r_tmem[w_tra];
    end

    // search compare and bracketing; a latitude above the last breakpoint takes the end interval
    assign w_hit  = i_cmd.lat ? (!r_above && (32'(r_qlat) <= r_ldat)) : (r_qlp <= r_pdat);
    assign w_last = i_cmd.lat ? (IW'(r_idx) == IW'(w_nl - LCW'(1)))
                              : (IW'(r_idx) == IW'(w_np - PCW'(1)));
    assign w_free = !r_ovalid || i_m_ready;

    assign o_stat.out_rng     = (r_qlp < r_b0) || (r_qlp > r_pdat);
    assign o_stat.hit_or_last = w_hit || w_last;
    assign o_stat.unit_done   = (r_cnt == '0);
    assign o_stat.out_free    = w_free;

    // divider operands
    always_comb begin
        w_q     = i_cmd.lat ? 33'(r_qlat) : 33'(r_qlp);
        w_lo    = i_cmd.lat ? 33'(r_ldat) : 33'(r_pdat);
        w_num   = w_q - w_lo;
        w_den   = 33'(r_b1) - w_lo;
        w_anum  = w_num[32] ? 32'(-w_num) : w_num[31:0];
        w_aden  = w_den[32] ? 32'(-w_den) : w_den[31:0];
        w_trial = {r_rem, r_dq[47]};
        w_frac  = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        if (r_dzero) w_frac = '0;
    end

    // multiplier operands and rounding
    always_comb begin
        case (i_cmd.sel)
            2'd0:    w_x = 48'(r_v01) - 48'(r_v00);
            2'd1:    w_x = 48'(r_v11) - 48'(r_v10);
            default: w_x = r_b - r_a;
        endcase
        w_y    = (i_cmd.sel == 2'd2) ? 31'(r_fp) : r_fl;
        w_ax   = w_x[47] ? 48'(-w_x) : 48'(w_x);
        w_ay   = w_y[30] ? -w_y : w_y;
        w_prod = r_mneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        w_rnd  = (w_prod + 79'sd32768) >>> 16;
        w_r64  = 64'(w_rnd);
        w_sum  = 64'(r_a) + w_r64;
        if (w_sum > 64'sd2147483647) w_sat = 32'sh7fffffff;
        else if (w_sum < -64'sd2147483648) w_sat = 32'sh80000000;
        else w_sat = 32'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            igbi_pkg::OP_ACCEPT: begin
                r_qlat <= i_qlat;
                r_qlp  <= i_qlp;
            end
            igbi_pkg::OP_RD_LAST: r_b0 <= r_pdat;
            igbi_pkg::OP_CHECK: begin
                r_idx   <= IW'(1);
                r_above <= (32'(r_qlat) > r_ldat);
            end
            igbi_pkg::OP_SRCH_CMP: begin
                if (w_hit || w_last) begin
                    r_b1 <= i_cmd.lat ? r_ldat : r_pdat;
                    if (i_cmd.lat) r_j <= LW'(r_idx - IW'(1));
                    else r_k <= PW'(r_idx - IW'(1));
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            igbi_pkg::OP_DIV_START: begin
                r_dq    <= {w_anum, 16'd0};
                r_dvs   <= w_aden;
                r_rem   <= '0;
                r_dneg  <= w_num[32] ^ w_den[32];
                r_dzero <= (w_den == '0);
                r_cnt   <= igbi_pkg::DIV_STEPS;
            end
            igbi_pkg::OP_DIV_STEP: begin
                if (r_cnt != '0) begin
                    if (w_trial >= {1'b0, r_dvs}) begin
                        r_rem <= 32'(w_trial - {1'b0, r_dvs});
                        r_dq  <= {r_dq[46:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[31:0];
                        r_dq  <= {r_dq[46:0], 1'b0};
                    end
                    r_cnt <= r_cnt - igbi_pkg::CNT_W'(1);
                end
            end
            igbi_pkg::OP_FRAC_STORE: begin
                r_idx <= IW'(1);
                if (i_cmd.lat) begin
                    if (w_frac > igbi_pkg::LAT_FRAC_LIMIT) r_fl <= 31'sd536870912;
                    else if (w_frac < -igbi_pkg::LAT_FRAC_LIMIT) r_fl <= -31'sd536870912;
                    else r_fl <= 31'(w_frac);
                end else begin
                    r_fp <= 18'(w_frac);
                end
            end
            igbi_pkg::OP_BASE: r_base <= TW'(TW'(r_k) * TW'(w_nl));
            igbi_pkg::OP_T_RD: begin
                case (i_cmd.sel)
                    2'd1:    r_v00 <= r_tdat;
                    2'd2:    r_v01 <= r_tdat;
                    2'd3:    r_v10 <= r_tdat;
                    default: ;
                endcase
            end
            igbi_pkg::OP_T_CAP: r_v11 <= r_tdat;
            igbi_pkg::OP_MUL_START: begin
                r_mx   <= 78'(w_ax);
                r_my   <= w_ay[29:0];
                r_acc  <= '0;
                r_mneg <= w_x[47] ^ w_y[30];
                r_cnt  <= igbi_pkg::MUL_STEPS;
            end
            igbi_pkg::OP_MUL_STEP: begin
                if (r_cnt != '0) begin
                    if (r_my[0]) r_acc <= r_acc + r_mx;
                    r_mx  <= {r_mx[76:0], 1'b0};
                    r_my  <= {1'b0, r_my[29:1]};
                    r_cnt <= r_cnt - igbi_pkg::CNT_W'(1);
                end
            end
            igbi_pkg::OP_MUL_STORE: begin
                if (i_cmd.sel == 2'd0) r_a <= 48'(64'(r_v00) + w_r64);
                if (i_cmd.sel == 2'd1) r_b <= 48'(64'(r_v10) + w_r64);
            end
            default: ;
        endcase
    end

    // result register and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pcfg   <= igbi_pkg::CFG_RESET;
            r_lcfg   <= igbi_pkg::CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == igbi_pkg::CFG_P_COUNT) r_pcfg <= i_cfg_wdata;
                if (i_cfg_idx == igbi_pkg::CFG_L_COUNT) r_lcfg <= i_cfg_wdata;
            end
            if (w_free && ((i_cmd.op == igbi_pkg::OP_ZERO) ||
                    ((i_cmd.op == igbi_pkg::OP_MUL_STORE) && (i_cmd.sel == 2'd2)))) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && (i_cmd.op == igbi_pkg::OP_ZERO)) begin
            r_odata  <= '0;
            r_orange <= 1'b0;
        end else if (w_free && (i_cmd.op == igbi_pkg::OP_MUL_STORE) && (i_cmd.sel == 2'd2)) begin
            r_odata  <= w_sat;
            r_orange <= 1'b1;
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_m_data  = r_odata;
    assign o_m_range = r_orange;

endmodule

>>> rtl/irregular_grid_bilinear_interpolator_top.sv
// Top level: bilinear interpolator over irregular log-pressure / latitude grid
//
// Input stream s_axis: tuser selects the item kind (load pressure breakpoint,
// load latitude breakpoint, load table value, query). Loads write one entry
// and give no result. A query gives one result item on m_axis: tdata is the
// interpolated Q16.16 value, tuser is the in-range flag.
// Config port: i_cfg_we writes i_cfg_wdata to count register i_cfg_idx
// (0 pressure points, 1 latitude points); write only while idle.
// Throughput: a load is accepted every cycle while idle. An in-range query goes
// through reads and checks, a read/compare step per breakpoint from index 1
// until the pressure and latitude brackets are found, two passes of a
// 48-step serial divider and three passes of a 30-step serial multiplier. An
// out-of-range query gives a zero result after the range check. No item is
// accepted while a query runs; the controller returns to idle as the query's
// result is registered.
// Reset (synchronous, active low) returns to idle and sets both counts to 2;
// memories keep their contents. If m_axis stalls, the result is held in the
// output register; the next item is accepted, and a later query waits at its end.
`timescale 1ns / 1ps
module irregular_grid_bilinear_interpolator_top #(
    parameter int MAX_PRESSURE_POINTS = 64,
    parameter int MAX_LATITUDE_POINTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // load_index, load_value, query_latitude, query_log_pressure, zero pad
    input  logic [igbi_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // kind
    input  logic [igbi_pkg::S_TUSER_W-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // heating_increment
    output logic [igbi_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // in_range
    output logic [igbi_pkg::M_TUSER_W-1:0]        m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [igbi_pkg::CFG_W-1:0]            i_cfg_wdata
);

    igbi_pkg::t_cmd  w_cmd;
    igbi_pkg::t_stat w_stat;
    logic signed [31:0] w_data;
    logic               w_range;

    igbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_is_query (s_axis_tuser == igbi_pkg::KIND_QUERY),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_ready    (s_axis_tready)
    );

    igbi_dp #(
        .MAX_P (MAX_PRESSURE_POINTS),
        .MAX_L (MAX_LATITUDE_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_axis_tuser),
        .i_index     (s_axis_tdata[11:0]),
        .i_value     ($signed(s_axis_tdata[43:12])),
        .i_qlat      ($signed(s_axis_tdata[67:44])),
        .i_qlp       ($signed(s_axis_tdata[99:68])),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (w_data),
        .o_m_range   (w_range)
    );

    assign m_axis_tdata = w_data;
    assign m_axis_tuser = w_range;

endmodule

>>> sim/tb_top.sv
// Testbench: interpolator grid loads and queries checked against a bilinear predictor
`timescale 1ns / 1ps
module tb_top;

    localparam int NP = 64;
    localparam int NL = 64;
    localparam int TFILL = 256;

    typedef struct {
        logic [31:0] value;
        logic        in_rng;
    } t_result;

    class interp_board;
        int          pbp[NP];
        int          lbp[NL];
        int          tbl[NP*NL];
        logic [6:0]  p_count_reg = igbi_pkg::CFG_RESET;
        logic [6:0]  l_count_reg = igbi_pkg::CFG_RESET;
        t_result     pending_results[$];
        int          errors = 0;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int eff(logic [6:0] r, int depth);
            if (r < 2) return 2;
            if (r > depth) return depth;
            return r;
        endfunction

        function longint frac(longint num, longint den);
            if (den == 0) return 0;
            return (num * 65536) / den;
        endfunction

        function longint rnd(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function void note_item(igbi_pkg::t_kind kind, logic [11:0] idx,
                                logic signed [31:0] val,
                                logic signed [23:0] lat, logic signed [31:0] lp);
            int np, nl, j, k;
            longint qlat, qlp, fl, fp, v00, v01, v10, v11, a, b, r;
            t_result res;
            case (kind)
                igbi_pkg::KIND_LOAD_P: if (idx < NP) pbp[idx] = val;
                igbi_pkg::KIND_LOAD_L: if (idx < NL) lbp[idx] = val;
                igbi_pkg::KIND_LOAD_T: tbl[idx] = val;
                default: begin
                    np = eff(p_count_reg, NP);
                    nl = eff(l_count_reg, NL);
                    qlat = lat;
                    qlp = lp;
                    if (qlp < pbp[0] || qlp > pbp[np-1]) begin
                        res.value = '0;
                        res.in_rng = 1'b0;
                    end else begin
                        j = nl - 2;
                        if (qlat <= lbp[nl-1]) begin
                            for (int i = 1; i < nl; i++) begin
                                if (qlat <= lbp[i]) begin
                                    j = i - 1;
                                    break;
                                end
                            end
                        end
                        fl = frac(qlat - lbp[j], longint'(lbp[j+1]) - lbp[j]);
                        if (fl > (64'sd1 <<< 29)) fl = 64'sd1 <<< 29;
                        if (fl < -(64'sd1 <<< 29)) fl = -(64'sd1 <<< 29);
                        k = np - 2;
                        for (int i = 1; i < np; i++) begin
                            if (qlp <= pbp[i]) begin
                                k = i - 1;
                                break;
                            end
                        end
                        fp = frac(qlp - pbp[k], longint'(pbp[k+1]) - pbp[k]);
                        v00 = tbl[k*nl + j];
                        v01 = tbl[k*nl + j + 1];
                        v10 = tbl[(k+1)*nl + j];
                        v11 = tbl[(k+1)*nl + j + 1];
                        a = v00 + rnd((v01 - v00) * fl);
                        b = v10 + rnd((v11 - v10) * fl);
                        r = a + rnd((b - a) * fp);
                        if (r > 64'sd2147483647) r = 64'sd2147483647;
                        if (r < -64'sd2147483648) r = -64'sd2147483648;
                        res.value = r[31:0];
                        res.in_rng = 1'b1;
                    end
                    pending_results.push_back(res);
                end
            endcase
        endfunction

        task check_result(logic [31:0] value, logic in_rng);
            t_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %h/%b", value, in_rng));
                return;
            end
            e = pending_results.pop_front();
            if (value !== e.value)
                report($sformatf("value got %h exp %h", value, e.value));
            if (in_rng !== e.in_rng)
                report($sformatf("in_range got %b exp %b", in_rng, e.in_rng));
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [igbi_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [igbi_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [igbi_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [igbi_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_idx = igbi_pkg::CFG_P_COUNT;
    logic [igbi_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    interp_board board = new();
    bit  no_idle = 0;
    int  hold_cycles = 0;

    irregular_grid_bilinear_interpolator_top DUT (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls plus an optional long hold
    initial begin
        int stall;
        stall = $urandom_range(0, 5);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tuser[0]);
                stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task send_item(igbi_pkg::t_kind kind, logic [11:0] idx, logic [31:0] val,
                   logic [23:0] lat, logic [31:0] lp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, lp, lat, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(kind, idx, val, lat, lp);
    endtask

    task drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_counts(logic [6:0] p, logic [6:0] l);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= igbi_pkg::CFG_P_COUNT;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_idx <= igbi_pkg::CFG_L_COUNT;
        i_cfg_wdata <= l;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.p_count_reg = p;
        board.l_count_reg = l;
    endtask

    // nondecreasing pressure breakpoints, step scale varies per call
    task load_pressure(int n);
        longint cur, step_max;
        step_max = 64'sd1 << $urandom_range(4, 27);
        cur = -64'sd2147483648 + ({$urandom, $urandom} % (64'sd1 << 31));
        if ($urandom_range(0, 3) == 0) cur = -64'sd2147483648;
        for (int i = 0; i < n; i++) begin
            send_item(igbi_pkg::KIND_LOAD_P, 12'(i), cur[31:0], 24'($urandom), $urandom);
            cur += ($urandom_range(0, 4) == 0) ? 0 : ({$urandom, $urandom} % step_max);
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        end
    endtask

    task load_latitude(bit sorted, int n);
        longint cur;
        cur = -64'sd6500000 + $urandom_range(0, 1000000);
        for (int i = 0; i < n; i++) begin
            if (sorted) begin
                send_item(igbi_pkg::KIND_LOAD_L, 12'(i), cur[31:0], 24'($urandom), $urandom);
                cur += $urandom_range(0, 400000);
            end else begin
                send_item(igbi_pkg::KIND_LOAD_L, 12'(i), $urandom, 24'($urandom), $urandom);
            end
        end
    endtask

    function logic [31:0] table_value();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
    endfunction

    function logic [23:0] pick_lat();
        int nl;
        longint v;
        nl = board.eff(board.l_count_reg, NL);
        case ($urandom_range(0, 3))
            0: v = longint'(board.lbp[$urandom_range(0, nl-1)])
                   + longint'($urandom_range(0, 200)) - 100;
            1: v = $urandom_range(0, 1) ? 5898240 : -5898240;
            default: v = longint'($urandom_range(0, 11796480)) - 5898240;
        endcase
        if (v > 5898240) v = 5898240;
        if (v < -5898240) v = -5898240;
        return v[23:0];
    endfunction

    function logic [31:0] pick_lp();
        int np;
        longint lo, hi, v;
        np = board.eff(board.p_count_reg, NP);
        lo = board.pbp[0];
        hi = board.pbp[np-1];
        case ($urandom_range(0, 9))
            0: v = $signed($urandom);
            1: v = board.pbp[$urandom_range(0, np-1)];
            2: v = lo - 1;
            default: v = lo + ({$urandom, $urandom} % (hi - lo + 1));
        endcase
        return v[31:0];
    endfunction

    task random_items(int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: send_item(igbi_pkg::KIND_LOAD_T, 12'($urandom), table_value(),
                                      24'($urandom), $urandom);
                4: send_item(igbi_pkg::KIND_LOAD_L, 12'($urandom_range(0, 70)), $urandom,
                             24'($urandom), $urandom);
                5: send_item(igbi_pkg::KIND_LOAD_P, 12'($urandom_range(64, 4095)), $urandom,
                             24'($urandom), $urandom);
                default: send_item(igbi_pkg::KIND_QUERY, 12'($urandom), $urandom,
                                   pick_lat(), pick_lp());
            endcase
        end
    endtask

    initial begin
        logic [6:0] pc [10];
        logic [6:0] lc [10];
        int pb0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill all breakpoints and the table rows that any phase's counts reach
        load_pressure(NP);
        load_latitude(1, NL);
        for (int i = 0; i < TFILL; i++)
            send_item(igbi_pkg::KIND_LOAD_T, 12'(i), table_value(), 24'($urandom), $urandom);
        send_item(igbi_pkg::KIND_LOAD_T, 12'd4095, 32'h8000_0000, '0, '0);
        send_item(igbi_pkg::KIND_LOAD_T, 12'd4094, 32'h7FFF_FFFF, '1, '1);

        // directed: range edges, field extremes, ignored loads, degenerate intervals
        pb0 = board.pbp[0];
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, pb0 - 1);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, board.pbp[1] + 1);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, pb0);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, board.pbp[1]);
        send_item(igbi_pkg::KIND_QUERY, '1, '1, -24'sd5898240, pb0);
        send_item(igbi_pkg::KIND_QUERY, '1, '1, 24'sd5898240, board.pbp[1]);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, 32'h8000_0000);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, 32'h7FFF_FFFF);
        send_item(igbi_pkg::KIND_LOAD_P, 12'd64, 32'h7FFF_FFFF, '0, '0);
        send_item(igbi_pkg::KIND_LOAD_P, 12'd4095, 32'h8000_0000, '0, '0);
        send_item(igbi_pkg::KIND_LOAD_L, 12'd4095, 32'h0, '0, '0);
        send_item(igbi_pkg::KIND_LOAD_P, 12'd1, pb0, '0, '0);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h100, pb0);
        send_item(igbi_pkg::KIND_LOAD_L, 12'd1, board.lbp[0], '0, '0);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0, pb0);
        send_item(igbi_pkg::KIND_LOAD_L, 12'd0, 32'h0000_1000, '0, '0);
        send_item(igbi_pkg::KIND_LOAD_L, 12'd1, 32'h0000_0F00, '0, '0);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, 24'h0001_0000, pb0);
        send_item(igbi_pkg::KIND_QUERY, '0, '0, -24'sd5898240, pb0);
        drain();

        // count pairs keep every flat table index below TFILL
        pc = '{7'd64, 7'd0, 7'd127, 7'd3, 7'd64, 7'd2, 7'd1, 7'd40, 7'd17, 7'd4};
        lc = '{7'd4, 7'd1, 7'd3, 7'd64, 7'd2, 7'd64, 7'd0, 7'd5, 7'd9, 7'd127};
        for (int ph = 0; ph < 10; ph++) begin
            write_counts(pc[ph], lc[ph]);
            no_idle = (ph == 4 || ph == 8);
            if (ph > 0) load_pressure(board.eff(board.p_count_reg, NP));
            load_latitude(ph % 3 != 2, board.eff(board.l_count_reg, NL));
            if (ph == 3) hold_cycles = 800;
            random_items(63);
            drain();
        end
        write_counts(igbi_pkg::CFG_RESET, igbi_pkg::CFG_RESET);

        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/igbi_pkg.sv
rtl/igbi_ctrl.sv
rtl/igbi_dp.sv
rtl/irregular_grid_bilinear_interpolator_top.sv
sim/tb_top.sv
